// ===== rtl/eeprom_emulation_log_controller_top_macros.svh =====
// ============================================================================
// eeprom_emulation_log_controller_top_macros.svh
// Assertion macros shared by the EEPROM emulation log controller RTL.
// ============================================================================
`ifndef EEPROM_EMULATION_LOG_CONTROLLER_TOP_MACROS_SVH
`define EEPROM_EMULATION_LOG_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define EELC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define EELC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EELC_ASSERT(label, prop, msg)
`define EELC_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/eelc_pkg.sv =====
// ============================================================================
// eelc_pkg
// Types, sizes and codes of the EEPROM emulation log controller.
// ============================================================================
package eelc_pkg;

    localparam int EEPROM_BYTES = 32;
    localparam int LOG_SLOTS    = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CACHE_AW = (EEPROM_BYTES > 1) ? $clog2(EEPROM_BYTES) : 1;
    localparam int FILL_W   = $clog2(LOG_SLOTS + 1);
    localparam int PROD_W   = FILL_W + 9;
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FILL_W-1:0] LOG_FULL = FILL_W'(LOG_SLOTS);
    localparam logic [FILL_W-1:0] LOG_LAST = FILL_W'(LOG_SLOTS - 1);

    localparam logic       REG_FLASH_BASE   = 1'b0;
    localparam logic       REG_SLOT_BYTES   = 1'b1;
    localparam logic [8:0] SLOT_BYTES_RESET = 9'd4;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REPLAY = 2'd2,
        OP_ERASE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_ERASE   = 2'd2
    } cmd_t;

    typedef struct packed {
        op_t                 op;
        logic                addr_ok;
        logic [CACHE_AW-1:0] idx;
        logic [7:0]          data;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        status;
        cmd_t        flash_cmd;
        logic [31:0] flash_address;
        logic [4:0]  record_address;
        logic [7:0]  record_data;
        logic        last;
    } res_t;

    function automatic logic [4:0] rec_addr(input logic [CACHE_AW-1:0] idx);
        logic [15:0] wide;
        wide = 16'(idx);
        return wide[4:0];
    endfunction

endpackage

// ===== rtl/eelc_front.sv =====
// ============================================================================
// eelc_front
// Input stage: takes requests, decodes the op and checks the address range.
// ============================================================================
module eelc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]          s_tuser,   // op[1:0]
    input  logic                q_ready,
    output logic                q_push,
    output eelc_pkg::item_t     q_item
);

    eelc_pkg::item_t item_reg;
    eelc_pkg::item_t item_next;
    logic            valid_reg;
    logic            valid_next;
    logic            accept;
    logic [15:0]     address;

    assign address  = s_tdata[15:0];
    assign s_tready = !valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = valid_reg && q_ready;
    assign q_item   = item_reg;

    always_comb
    begin
        item_next = item_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            item_next.op      = eelc_pkg::op_t'(s_tuser);
            item_next.addr_ok = address < 16'(eelc_pkg::EEPROM_BYTES);
            item_next.idx     = address[eelc_pkg::CACHE_AW-1:0];
            item_next.data    = s_tdata[23:16];
            valid_next        = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== rtl/eelc_queue.sv =====
// ============================================================================
// eelc_queue
// Short request queue between the front and the execution back end.
// ============================================================================
`include "eeprom_emulation_log_controller_top_macros.svh"

module eelc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  eelc_pkg::item_t push_item,
    output logic            ready,
    input  logic            pop,
    output logic            head_valid,
    output eelc_pkg::item_t head_item
);

    eelc_pkg::item_t                 entries_reg [eelc_pkg::QUEUE_DEPTH];
    logic [eelc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [eelc_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [eelc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [eelc_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [eelc_pkg::QCNT_W-1:0]     count_reg;
    logic [eelc_pkg::QCNT_W-1:0]     count_next;

    localparam logic [eelc_pkg::QPTR_W-1:0] PTR_END = eelc_pkg::QPTR_W'(eelc_pkg::QUEUE_DEPTH - 1);
    localparam logic [eelc_pkg::QCNT_W-1:0] CNT_FULL = eelc_pkg::QCNT_W'(eelc_pkg::QUEUE_DEPTH);

    assign ready      = count_reg != CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_END) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_END) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    `EELC_NEVER(a_no_push_full, push && !ready, "queue push while full")
    `EELC_NEVER(a_no_pop_empty, pop && !head_valid, "queue pop while empty")
    `EELC_ASSERT(a_count_range, count_reg <= CNT_FULL, "queue count beyond depth")

endmodule

// ===== rtl/eelc_back.sv =====
// ============================================================================
// eelc_back
// Execution back end: byte cache, log fill pointer, compaction sequencer
// and result register.
// ============================================================================
`include "eeprom_emulation_log_controller_top_macros.svh"

module eelc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     flash_base,
    input  logic [8:0]      slot_bytes,
    input  logic            head_valid,
    input  eelc_pkg::item_t head_item,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_ready,
    output eelc_pkg::res_t  res
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [7:0]                      cache_reg [eelc_pkg::EEPROM_BYTES];
    logic [7:0]                      cache_next [eelc_pkg::EEPROM_BYTES];
    logic [eelc_pkg::FILL_W-1:0]     fill_reg;
    logic [eelc_pkg::FILL_W-1:0]     fill_next;
    logic                            replay_done_reg;
    logic                            replay_done_next;
    logic [eelc_pkg::CACHE_AW-1:0]   scan_idx_reg;
    logic [eelc_pkg::CACHE_AW-1:0]   scan_idx_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    eelc_pkg::res_t                  out_reg;
    eelc_pkg::res_t                  out_next;

    logic                            out_free;
    logic [eelc_pkg::CACHE_AW-1:0]   rd_idx;
    logic [7:0]                      rd_byte;
    logic [eelc_pkg::EEPROM_BYTES-1:0] nz;
    logic [eelc_pkg::EEPROM_BYTES-1:0] nz_upd;
    logic [eelc_pkg::EEPROM_BYTES-1:0] higher;
    logic [eelc_pkg::PROD_W-1:0]     prod;
    logic [31:0]                     slot_addr;

    assign out_free  = !out_valid_reg || res_ready;
    assign rd_idx    = (state_reg == ST_SCAN) ? scan_idx_reg : head_item.idx;
    assign rd_byte   = cache_reg[rd_idx];
    assign prod      = eelc_pkg::PROD_W'(fill_reg) * eelc_pkg::PROD_W'(slot_bytes);
    assign slot_addr = flash_base + 32'(prod);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        for (int i = 0; i < eelc_pkg::EEPROM_BYTES; i++)
        begin
            nz[i]     = |cache_reg[i];
            higher[i] = eelc_pkg::CACHE_AW'(i) > scan_idx_reg;
        end
        nz_upd = nz;
        nz_upd[head_item.idx] = |head_item.data;
    end

    always_comb
    begin
        state_next       = state_reg;
        cache_next       = cache_reg;
        fill_next        = fill_reg;
        replay_done_next = replay_done_reg;
        scan_idx_next    = scan_idx_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        pop              = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    unique case (head_item.op)
                        eelc_pkg::OP_READ:
                        begin
                            out_next.read_data = head_item.addr_ok ? rd_byte : 8'd0;
                        end
                        eelc_pkg::OP_WRITE:
                        begin
                            replay_done_next = 1'b1;
                            if (!head_item.addr_ok)
                            begin
                                out_next.status = 1'b1;
                            end
                            else if (rd_byte != head_item.data)
                            begin
                                cache_next[head_item.idx] = head_item.data;
                                if (fill_reg < eelc_pkg::LOG_FULL)
                                begin
                                    out_next.flash_cmd      = eelc_pkg::CMD_PROGRAM;
                                    out_next.flash_address  = slot_addr;
                                    out_next.record_address = eelc_pkg::rec_addr(head_item.idx);
                                    out_next.record_data    = head_item.data;
                                    fill_next               = fill_reg + 1'b1;
                                end
                                else
                                begin
                                    out_next.flash_cmd = eelc_pkg::CMD_ERASE;
                                    out_next.last      = !(|nz_upd);
                                    fill_next          = '0;
                                    scan_idx_next      = '0;
                                    if (|nz_upd)
                                    begin
                                        state_next = ST_SCAN;
                                    end
                                end
                            end
                        end
                        eelc_pkg::OP_REPLAY:
                        begin
                            if (!replay_done_reg)
                            begin
                                if (!head_item.addr_ok || fill_reg >= eelc_pkg::LOG_FULL)
                                begin
                                    replay_done_next = 1'b1;
                                end
                                else
                                begin
                                    cache_next[head_item.idx] = head_item.data;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        eelc_pkg::OP_ERASE:
                        begin
                            replay_done_next   = 1'b1;
                            fill_next          = '0;
                            out_next.flash_cmd = eelc_pkg::CMD_ERASE;
                            for (int i = 0; i < eelc_pkg::EEPROM_BYTES; i++)
                            begin
                                cache_next[i] = 8'd0;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!nz[scan_idx_reg])
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next                = '0;
                    out_next.flash_cmd      = eelc_pkg::CMD_PROGRAM;
                    out_next.flash_address  = slot_addr;
                    out_next.record_address = eelc_pkg::rec_addr(scan_idx_reg);
                    out_next.record_data    = rd_byte;
                    out_next.last           = !(|(nz & higher)) ||
                                              (fill_reg == eelc_pkg::LOG_LAST);
                    fill_next               = fill_reg + 1'b1;
                    scan_idx_next           = scan_idx_reg + 1'b1;
                    if (out_next.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            replay_done_reg <= 1'b0;
            scan_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            for (int i = 0; i < eelc_pkg::EEPROM_BYTES; i++)
            begin
                cache_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            replay_done_reg <= replay_done_next;
            scan_idx_reg    <= scan_idx_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            cache_reg       <= cache_next;
        end
    end

    `EELC_ASSERT(a_fill_range, fill_reg <= eelc_pkg::LOG_FULL, "log fill beyond slot count")
    `EELC_NEVER(a_no_pop_in_scan, state_reg == ST_SCAN && pop, "request taken during compaction")
    `EELC_ASSERT(a_replay_done_sticky, replay_done_reg |=> replay_done_reg, "replay_done cleared")

endmodule

// ===== rtl/eeprom_emulation_log_controller_top.sv =====
// ============================================================================
// eeprom_emulation_log_controller_top
// EEPROM emulation on an append-only flash log, with a cached byte image.
// ============================================================================
// Requests enter on the s_t* stream (op in tuser, address and data in tdata).
// Results leave on the m_t* stream; m_tlast marks the final result of a
// request, and m_tuser carries the flash command of each result.
// Read, replay, erase and ordinary writes give one result each. A write that
// finds the log full gives an erase result and then one program result per
// non-zero cached byte, in ascending address order.
// The first result of a request passes the input stage register, a queue entry
// and the output register. Single-result requests sustain one per cycle
// while the receiver does not stall. Compaction walks the byte cache one entry
// per cycle unless the receiver stalls, and takes no new request meanwhile.
// A two-entry queue separates the input stage from execution; while the
// receiver stalls, results hold in the output register, the queue and the
// input stage register fill, and then s_tready drops.
// Reset clears the cache, the fill pointer, the replay flag and all valids;
// flash_base resets to 0 and slot_bytes to 4. Registers sit on the APB port
// at byte addresses 0 and 4 and should be written only while the block idles.
// ============================================================================
module eeprom_emulation_log_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // read_data[7:0], status[8], flash_address[40:9],
                                   // record_address[45:41], record_data[53:46], zero pad
    output logic [1:0]  m_tuser,   // flash_cmd[1:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]     flash_base_reg;
    logic [31:0]     flash_base_next;
    logic [8:0]      slot_bytes_reg;
    logic [8:0]      slot_bytes_next;
    logic            cfg_wr;

    logic            q_push;
    logic            q_ready;
    eelc_pkg::item_t q_item;
    logic            pop;
    logic            head_valid;
    eelc_pkg::item_t head_item;
    eelc_pkg::res_t  res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        flash_base_next = flash_base_reg;
        slot_bytes_next = slot_bytes_reg;
        prdata          = '0;
        unique case (paddr[2])
            eelc_pkg::REG_FLASH_BASE:
            begin
                prdata = flash_base_reg;
                if (cfg_wr)
                begin
                    flash_base_next = pwdata;
                end
            end
            eelc_pkg::REG_SLOT_BYTES:
            begin
                prdata = 32'(slot_bytes_reg);
                if (cfg_wr)
                begin
                    slot_bytes_next = pwdata[8:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg <= '0;
            slot_bytes_reg <= eelc_pkg::SLOT_BYTES_RESET;
        end
        else
        begin
            flash_base_reg <= flash_base_next;
            slot_bytes_reg <= slot_bytes_next;
        end
    end

    eelc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    eelc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    eelc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .flash_base (flash_base_reg),
        .slot_bytes (slot_bytes_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.record_data, res.record_address, res.flash_address,
                      res.status, res.read_data};
    assign m_tuser = res.flash_cmd;
    assign m_tlast = res.last;

endmodule
